@@ hw/rtl/rci_pkg.sv @@
// rci_pkg: widths, cell state types and result type for the ray/circle
// intersection pipeline. No dependencies.
`default_nettype none
package rci_pkg;

	localparam int SQ_CELLS  = 31;	// one root bit per cell
	localparam int DIV_CELLS = 49;	// one quotient bit per cell
	localparam int RAD_W     = 62;
	localparam int ROOT_W    = 31;
	localparam int REM_W     = 33;
	localparam int NUM_W     = 49;
	localparam int DVS_W     = 32;

	typedef struct packed {
		logic signed [33:0] h;
		logic [DVS_W-1:0]   a;
		logic signed [31:0] tlo;
		logic signed [31:0] thi;
		logic               nohit;
	} sq_side_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
		sq_side_t          side;
	} sq_st_t;

	typedef struct packed {
		logic [DVS_W-1:0]   a;
		logic signed [31:0] tlo;
		logic signed [31:0] thi;
		logic               nohit;
		logic               neg0;
		logic               neg1;
	} dv_side_t;

	typedef struct packed {
		logic [NUM_W-1:0] n0;
		logic [NUM_W-1:0] n1;
		logic [NUM_W-1:0] q0;
		logic [NUM_W-1:0] q1;
		logic [DVS_W-1:0] r0;
		logic [DVS_W-1:0] r1;
		dv_side_t         side;
	} dv_st_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] t_hit;
	} res_t;

endpackage
`default_nettype wire

@@ hw/rtl/rci_in_if.sv @@
// rci_in_if: query channel, valid/ready with the query fields.
// No dependencies.
`default_nettype none
interface rci_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic [14:0]        radius;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [31:0] t_lower;
	logic signed [31:0] t_upper;

	modport source (output valid, center_x, center_y, radius, origin_x, origin_y,
		dir_x, dir_y, t_lower, t_upper, input ready);
	modport sink (input valid, center_x, center_y, radius, origin_x, origin_y,
		dir_x, dir_y, t_lower, t_upper, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rci_out_if.sv @@
// rci_out_if: result channel, valid/ready with hit and t_hit.
// No dependencies.
`default_nettype none
interface rci_out_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] t_hit;

	modport source (output valid, hit, t_hit, input ready);
	modport sink (input valid, hit, t_hit, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rci_sqrt_cell.sv @@
// rci_sqrt_cell: one restoring square-root step, two radicand bits in,
// one root bit out. Depends on rci_pkg.
`default_nettype none
module rci_sqrt_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_in,
	input  wire rci_pkg::sq_st_t st_in,
	output logic                 v_out_q,
	output rci_pkg::sq_st_t      st_out_q
);
	import rci_pkg::*;

	logic [REM_W+1:0] cand;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;

	always_comb begin
		cand  = {st_in.rem, st_in.rad[RAD_W-1 -: 2]};
		trial = {2'b00, st_in.root, 2'b01};
		diff  = cand - trial;
		ge    = (cand >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out_q.rad  <= {st_in.rad[RAD_W-3:0], 2'b00};
			st_out_q.root <= {st_in.root[ROOT_W-2:0], ge};
			st_out_q.rem  <= ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
			st_out_q.side <= st_in.side;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/rci_div_cell.sv @@
// rci_div_cell: one restoring division step for both roots, one quotient
// bit each against the shared divisor. Depends on rci_pkg.
`default_nettype none
module rci_div_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_in,
	input  wire rci_pkg::dv_st_t st_in,
	output logic                 v_out_q,
	output rci_pkg::dv_st_t      st_out_q
);
	import rci_pkg::*;

	logic [DVS_W:0] cand0, cand1, dvs, diff0, diff1;
	logic           ge0, ge1;

	always_comb begin
		dvs   = {1'b0, st_in.side.a};
		cand0 = {st_in.r0, st_in.n0[NUM_W-1]};
		cand1 = {st_in.r1, st_in.n1[NUM_W-1]};
		diff0 = cand0 - dvs;
		diff1 = cand1 - dvs;
		ge0   = (cand0 >= dvs);
		ge1   = (cand1 >= dvs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out_q.n0   <= {st_in.n0[NUM_W-2:0], 1'b0};
			st_out_q.n1   <= {st_in.n1[NUM_W-2:0], 1'b0};
			st_out_q.q0   <= {st_in.q0[NUM_W-2:0], ge0};
			st_out_q.q1   <= {st_in.q1[NUM_W-2:0], ge1};
			st_out_q.r0   <= ge0 ? diff0[DVS_W-1:0] : cand0[DVS_W-1:0];
			st_out_q.r1   <= ge1 ? diff1[DVS_W-1:0] : cand1[DVS_W-1:0];
			st_out_q.side <= st_in.side;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/ray_circle_intersection.sv @@
// Ray/circle intersection, 2D fixed point: Q8.8 geometry in, Q16.16 hit parameter out.
// Pipeline: 5 front stages, 31 root cells, 1 numerator stage, 49 divide cells and
// 2 finishing stages. Throughput: one query per cycle unless a full result buffer
// holds the pipeline; the divide chain sets the depth, not the rate.
// A two-entry result buffer lets queries keep flowing while a result waits.
// Reset (arst_n, asynchronous, active low) clears all valid bits and the buffer count.
// Depends on rci_pkg, rci_in_if, rci_out_if, rci_sqrt_cell, rci_div_cell.
`default_nettype none
module ray_circle_intersection (
	input  wire logic clk,
	input  wire logic arst_n,
	rci_in_if.sink    query,
	rci_out_if.source result
);
	import rci_pkg::*;

	logic en;

	// ---------------- front: H = O - C, products, sums, squares ----------------
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [16:0] hx_s1, hy_s1;
	logic signed [15:0] dx_s1, dy_s1;
	logic [14:0]        r_s1;
	logic signed [31:0] tlo_s1, thi_s1, tlo_s2, thi_s2, tlo_s3, thi_s3;
	logic signed [31:0] tlo_s4, thi_s4, tlo_s5, thi_s5;
	logic signed [31:0] dxx_s2, dyy_s2;
	logic signed [32:0] hxdx_s2, hydy_s2, hxdy_s2, hydx_s2;
	logic [29:0]        r2_s2, r2_s3;
	logic [31:0]        a_s3, a_s4, a_s5;
	logic signed [33:0] h_s3, h_s4, h_s5;
	logic [31:0]        cm_s3;
	logic [63:0]        cross2_s4;
	logic [61:0]        ar2_s4, disc_s5;
	logic               nohit_s5;

	logic signed [33:0] cr_c;
	logic [33:0]        crm_c;

	always_comb begin
		cr_c  = 34'(hxdy_s2) - 34'(hydx_s2);
		crm_c = cr_c[33] ? 34'(-cr_c) : 34'(cr_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: register the query, form H
			hx_s1  <= 17'(query.origin_x) - 17'(query.center_x);
			hy_s1  <= 17'(query.origin_y) - 17'(query.center_y);
			dx_s1  <= query.dir_x;
			dy_s1  <= query.dir_y;
			r_s1   <= query.radius;
			tlo_s1 <= query.t_lower;
			thi_s1 <= query.t_upper;
			// stage 2: all narrow products side by side
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			hxdx_s2 <= hx_s1 * dx_s1;
			hydy_s2 <= hy_s1 * dy_s1;
			hxdy_s2 <= hx_s1 * dy_s1;
			hydx_s2 <= hy_s1 * dx_s1;
			r2_s2   <= r_s1 * r_s1;
			tlo_s2  <= tlo_s1;
			thi_s2  <= thi_s1;
			// stage 3: a = D.D, h = H.D, |H x D|
			a_s3   <= 32'(dxx_s2) + 32'(dyy_s2);
			h_s3   <= 34'(hxdx_s2) + 34'(hydy_s2);
			cm_s3  <= crm_c[31:0];
			r2_s3  <= r2_s2;
			tlo_s3 <= tlo_s2;
			thi_s3 <= thi_s2;
			// stage 4: cross squared and a*r^2
			cross2_s4 <= cm_s3 * cm_s3;
			ar2_s4    <= a_s3 * r2_s3;
			a_s4      <= a_s3;
			h_s4      <= h_s3;
			tlo_s4    <= tlo_s3;
			thi_s4    <= thi_s3;
			// stage 5: reduced discriminant and early miss
			nohit_s5 <= (a_s4 == 32'd0) || (cross2_s4 > 64'(ar2_s4));
			disc_s5  <= ar2_s4 - cross2_s4[61:0];
			a_s5     <= a_s4;
			h_s5     <= h_s4;
			tlo_s5   <= tlo_s4;
			thi_s5   <= thi_s4;
		end
	end

	// ---------------- square root: a row of cells, one root bit each ----------------
	logic   sq_v  [0:SQ_CELLS];
	sq_st_t sq_st [0:SQ_CELLS];

	always_comb begin
		sq_v[0]             = v_s5;
		sq_st[0].rad        = disc_s5;
		sq_st[0].root       = '0;
		sq_st[0].rem        = '0;
		sq_st[0].side.h     = h_s5;
		sq_st[0].side.a     = a_s5;
		sq_st[0].side.tlo   = tlo_s5;
		sq_st[0].side.thi   = thi_s5;
		sq_st[0].side.nohit = nohit_s5;
	end

	for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
		rci_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (sq_v[k]),
			.st_in    (sq_st[k]),
			.v_out_q  (sq_v[k+1]),
			.st_out_q (sq_st[k+1])
		);
	end

	// ---------------- numerators: (-h -/+ s) * 2^16, split to sign and magnitude ------
	logic               v_p;
	dv_st_t             dv_p;
	logic signed [34:0] nh_c, s_c, n0_c, n1_c;
	logic [34:0]        m0_c, m1_c;

	always_comb begin
		nh_c = -35'(sq_st[SQ_CELLS].side.h);
		s_c  = 35'(sq_st[SQ_CELLS].root);
		n0_c = nh_c - s_c;
		n1_c = nh_c + s_c;
		m0_c = n0_c[34] ? 35'(-n0_c) : 35'(n0_c);
		m1_c = n1_c[34] ? 35'(-n1_c) : 35'(n1_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= sq_v[SQ_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_p.n0         <= {m0_c[32:0], 16'd0};
			dv_p.n1         <= {m1_c[32:0], 16'd0};
			dv_p.q0         <= '0;
			dv_p.q1         <= '0;
			dv_p.r0         <= '0;
			dv_p.r1         <= '0;
			dv_p.side.a     <= sq_st[SQ_CELLS].side.a;
			dv_p.side.tlo   <= sq_st[SQ_CELLS].side.tlo;
			dv_p.side.thi   <= sq_st[SQ_CELLS].side.thi;
			dv_p.side.nohit <= sq_st[SQ_CELLS].side.nohit;
			dv_p.side.neg0  <= n0_c[34];
			dv_p.side.neg1  <= n1_c[34];
		end
	end

	// ---------------- divide: a row of cells, one quotient bit of each root per cell ---
	logic   dv_v  [0:DIV_CELLS];
	dv_st_t dv_st [0:DIV_CELLS];

	assign dv_v[0]  = v_p;
	assign dv_st[0] = dv_p;

	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_dv
		rci_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (dv_v[k]),
			.st_in    (dv_st[k]),
			.v_out_q  (dv_v[k+1]),
			.st_out_q (dv_st[k+1])
		);
	end

	// ---------------- finish: apply signs, then window test and saturate ----------------
	logic               v_f1;
	logic signed [49:0] t0_f1, t1_f1;
	logic signed [31:0] tlo_f1, thi_f1;
	logic               nohit_f1;
	dv_st_t             dq;

	assign dq = dv_st[DIV_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
		end else if (en) begin
			v_f1 <= dv_v[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_f1    <= dq.side.neg0 ? -50'(dq.q0) : 50'(dq.q0);
			t1_f1    <= dq.side.neg1 ? -50'(dq.q1) : 50'(dq.q1);
			tlo_f1   <= dq.side.tlo;
			thi_f1   <= dq.side.thi;
			nohit_f1 <= dq.side.nohit;
		end
	end

	logic signed [49:0] tsel_c;
	logic               miss_c;
	res_t               res_c;

	always_comb begin
		miss_c = nohit_f1 || (t0_f1 > 50'(thi_f1)) || (t1_f1 < 50'(tlo_f1));
		tsel_c = (t0_f1 < 50'(tlo_f1)) ? t1_f1 : t0_f1;
		res_c.hit = !miss_c;
		if (miss_c) begin
			res_c.t_hit = '0;
		end else if (tsel_c > 50'sd2147483647) begin
			res_c.t_hit = 32'sh7FFF_FFFF;
		end else if (tsel_c < -50'sd2147483648) begin
			res_c.t_hit = 32'sh8000_0000;
		end else begin
			res_c.t_hit = tsel_c[31:0];
		end
	end

	// ---------------- result buffer: two entries, head at index 0 ----------------
	res_t       ob_q [0:1];
	logic [1:0] cnt_q;
	logic       push, pop;
	logic [1:0] wr_c;

	// hold the whole pipeline only when a result is ready and the buffer is full
	assign en   = !(v_f1 && (cnt_q == 2'd2));
	assign push = en && v_f1;
	assign pop  = result.valid && result.ready;
	assign wr_c = cnt_q - {1'b0, pop};

	assign query.ready  = en;
	assign result.valid = (cnt_q != 2'd0);
	assign result.hit   = ob_q[0].hit;
	assign result.t_hit = ob_q[0].t_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// a new result lands in the head when the buffer is empty after this pop,
	// otherwise in the second entry; a pop moves the second entry to the head
	always_ff @(posedge clk) begin
		if (push && !wr_c[0]) begin
			ob_q[0] <= res_c;
		end else if (pop) begin
			ob_q[0] <= ob_q[1];
		end
		if (push && wr_c[0]) begin
			ob_q[1] <= res_c;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_f1 && cnt_q == 2'd2) |-> !query.ready)
		else $error("query taken while the pipeline is held");

	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_f1) && $stable(t0_f1))
		else $error("last stage moved during a hold");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |-> (result.t_hit == 32'sd0))
		else $error("miss carries a non-zero parameter");
`endif

endmodule
`default_nettype wire
